### rtl/hdc_pkg.sv
// Shared types and constants for the hyperdimensional classifier.
// Used by hdc_mac and hdc_encode_classify; depends on nothing.
`default_nettype none

package hdc_pkg;

  localparam int FEATURES_C = 64;
  localparam int DIM_C      = 512;
  localparam int CLASSES_C  = 16;

  localparam int OP_W        = 2;
  localparam int ADDR_W      = 15;
  localparam int VALUE_W     = 16;
  localparam int CLASS_OUT_W = 4;
  localparam int SCORE_OUT_W = 26;
  localparam int ADDR_SPACE  = 32768;

  localparam int SCORE_MAX_C = 33554431;
  localparam int SCORE_MIN_C = -33554432;

  localparam logic [OP_W-1:0] OP_BASE   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLASS  = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC,
    ST_ENC_WAIT,
    ST_CLS,
    ST_CLS_WAIT,
    ST_ARG,
    ST_ARG_WAIT,
    ST_OUT
  } state_t;

  // control that travels with one multiply-accumulate operand pair
  typedef struct packed {
    logic vld;
    logic first;
    logic lastf;
  } mac_ctl_t;

endpackage

`default_nettype wire

### rtl/hdc_encode_classify.sv
// Hyperdimensional classifier: weight loads, sample buffer, encode and score.
// Load items and non-final features are accepted without a stall. A final feature
// stalls the input while the stored features are encoded and every class is scored,
// and while an earlier result still waits on the output: the shared
// multiplier does one product per cycle, then the score adder one class weight per
// cycle. Reset clears sequencer, feature count and output valid; no clearing pass.
`default_nettype none

module hdc_encode_classify
  import hdc_pkg::*;
#(
  parameter int FEATURES = FEATURES_C,
  parameter int DIM      = DIM_C,
  parameter int CLASSES  = CLASSES_C
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [OP_W-1:0]               op,
  input  wire logic [ADDR_W-1:0]             addr,
  input  wire logic signed [VALUE_W-1:0]     value,
  input  wire logic                          last,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [CLASS_OUT_W-1:0]             predicted_class,
  output logic signed [SCORE_OUT_W-1:0]      best_score
);

  localparam int BASE_N = FEATURES * DIM;
  localparam int BASE_D = (BASE_N > ADDR_SPACE) ? ADDR_SPACE : BASE_N;
  localparam int BAW    = (BASE_D > 1) ? $clog2(BASE_D) : 1;
  localparam int BPW    = (BASE_N > 1) ? $clog2(BASE_N) : 1;
  localparam int CLS_N  = DIM * CLASSES;
  localparam int CLS_D  = (CLS_N > ADDR_SPACE) ? ADDR_SPACE : CLS_N;
  localparam int CAW    = (CLS_D > 1) ? $clog2(CLS_D) : 1;
  localparam int CPW    = (CLS_N > 1) ? $clog2(CLS_N) : 1;
  localparam int SAW    = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int CNTW   = $clog2(FEATURES + 1);
  localparam int DAW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int KW     = $clog2(CLASSES);
  localparam int ACC_W  = 2 * VALUE_W + $clog2(FEATURES);
  localparam int SW     = VALUE_W + $clog2(DIM + 1);
  localparam int SATW   = (SW > SCORE_OUT_W) ? SW : SCORE_OUT_W;

  localparam logic signed [SATW-1:0] SMAX = SATW'(SCORE_MAX_C);
  localparam logic signed [SATW-1:0] SMIN = SATW'(SCORE_MIN_C);

  // memories
  logic signed [VALUE_W-1:0] sample_mem [FEATURES];
  logic signed [VALUE_W-1:0] base_mem   [BASE_D];
  logic signed [VALUE_W-1:0] class_mem  [CLS_D];
  logic                      sign_mem   [DIM];
  logic signed [SW-1:0]      score_mem  [CLASSES];

  state_t state;
  state_t state_next;

  logic            accept;
  logic            start;
  logic            cnt_inc;
  logic [CNTW-1:0] cnt;
  logic [CNTW-1:0] cnt_new;
  logic [SAW-1:0]  nlast;

  // sequencer decode
  logic enc_issue;
  logic cls_issue;
  logic arg_issue;
  logic out_load;
  logic enc_end;
  logic cls_end;
  logic arg_end;
  logic d_end;
  logic k_end;
  logic lastf;

  // counters
  logic [SAW-1:0] f;
  logic [DAW-1:0] d;
  logic [KW-1:0]  k;
  logic [BPW-1:0] bp;
  logic [CPW-1:0] cp;

  // encode read stage
  mac_ctl_t                  ctl_b;
  logic signed [VALUE_W-1:0] sample_rd;
  logic signed [VALUE_W-1:0] base_rd;
  logic [DAW-1:0]            d_b;
  logic [DAW-1:0]            d_1;
  logic [DAW-1:0]            d_2;
  logic                      sign_we;
  logic                      sign_bit;
  logic                      mac_busy;

  // score stage
  logic                      vc;
  logic                      firstc;
  logic [KW-1:0]             kc;
  logic signed [VALUE_W-1:0] class_rd;
  logic                      sign_rd;
  logic signed [SW-1:0]      score_rd;
  logic signed [SW-1:0]      wv;
  logic signed [SW-1:0]      score_new;

  // argmax stage
  logic                      va;
  logic [KW-1:0]             ka;
  logic signed [SW-1:0]      best;
  logic [KW-1:0]             bestk;
  logic signed [SATW-1:0]    best_x;
  logic signed [SATW-1:0]    best_sat;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign start    = accept & (op == OP_SAMPLE) & last;
  assign cnt_inc  = (cnt < CNTW'(FEATURES));
  assign cnt_new  = cnt + CNTW'(cnt_inc);

  assign lastf   = (f == nlast);
  assign d_end   = (d == DAW'(DIM - 1));
  assign k_end   = (k == KW'(CLASSES - 1));
  assign enc_end = enc_issue & lastf & d_end;
  assign cls_end = cls_issue & k_end & d_end;
  assign arg_end = arg_issue & k_end;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (start) state_next = ST_ENC;
      ST_ENC:      if (enc_end) state_next = ST_ENC_WAIT;
      ST_ENC_WAIT: if (!ctl_b.vld && !mac_busy) state_next = ST_CLS;
      ST_CLS:      if (cls_end) state_next = ST_CLS_WAIT;
      ST_CLS_WAIT: if (!vc) state_next = ST_ARG;
      ST_ARG:      if (arg_end) state_next = ST_ARG_WAIT;
      ST_ARG_WAIT: if (!va) state_next = ST_OUT;
      ST_OUT:      if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    enc_issue = 1'b0;
    cls_issue = 1'b0;
    arg_issue = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_ENC:  enc_issue = 1'b1;
      ST_CLS:  cls_issue = 1'b1;
      ST_ARG:  arg_issue = 1'b1;
      ST_OUT:  out_load  = ~out_valid | ~out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // loads and feature buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept && op == OP_SAMPLE) begin
      cnt <= last ? '0 : cnt_new;
    end
    if (accept && op == OP_SAMPLE && cnt_inc) begin
      sample_mem[cnt[SAW-1:0]] <= value;
    end
    if (start) begin
      nlast <= SAW'(cnt_new - CNTW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_BASE && 32'(addr) < 32'(BASE_N)) begin
      base_mem[addr[BAW-1:0]] <= value;
    end
    base_rd   <= base_mem[bp[BAW-1:0]];
    sample_rd <= sample_mem[f];
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_CLASS && 32'(addr) < 32'(CLS_N)) begin
      class_mem[addr[CAW-1:0]] <= value;
    end
    class_rd <= class_mem[cp[CAW-1:0]];
  end

  // counters: column walk during encode, class walk during scoring and argmax
  always_ff @(posedge clk) begin
    if (start) begin
      f  <= '0;
      d  <= '0;
      bp <= '0;
    end else if (enc_issue) begin
      if (lastf) begin
        f  <= '0;
        d  <= d_end ? '0 : d + DAW'(1);
        bp <= BPW'(d) + BPW'(1);
      end else begin
        f  <= f + SAW'(1);
        bp <= bp + BPW'(DIM);
      end
    end else if (cls_issue && k_end) begin
      d <= d_end ? '0 : d + DAW'(1);
    end
    if (start) begin
      k  <= '0;
      cp <= '0;
    end else if (cls_issue || arg_issue) begin
      k  <= k_end ? '0 : k + KW'(1);
      cp <= cp + CPW'(1);
    end
  end

  // encode: operands to the shared multiplier, signs back into memory
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_b <= '0;
    end else begin
      ctl_b.vld   <= enc_issue;
      ctl_b.first <= (f == '0);
      ctl_b.lastf <= lastf;
    end
    d_b <= d;
    d_1 <= d_b;
    d_2 <= d_1;
    if (sign_we) begin
      sign_mem[d_2] <= sign_bit;
    end
    sign_rd <= sign_mem[d];
  end

  hdc_mac #(
    .ACC_W(ACC_W)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl_b),
    .a       (sample_rd),
    .b       (base_rd),
    .sign_we (sign_we),
    .sign_bit(sign_bit),
    .busy    (mac_busy)
  );

  // scoring: add or subtract one class weight per cycle
  assign wv        = sign_rd ? SW'(class_rd) : -SW'(class_rd);
  assign score_new = firstc ? wv : score_rd + wv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
      va <= 1'b0;
    end else begin
      vc <= cls_issue;
      va <= arg_issue;
    end
    kc       <= k;
    ka       <= k;
    firstc   <= (d == '0);
    score_rd <= score_mem[k];
    if (vc) begin
      score_mem[kc] <= score_new;
    end
    // keep the first index on ties
    if (va && (ka == '0 || score_rd > best)) begin
      best  <= score_rd;
      bestk <= ka;
    end
  end

  // result register
  assign best_x = SATW'(best);

  always_comb begin
    if (best_x > SMAX) begin
      best_sat = SMAX;
    end else if (best_x < SMIN) begin
      best_sat = SMIN;
    end else begin
      best_sat = best_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      predicted_class <= CLASS_OUT_W'(bestk);
      best_score      <= best_sat[SCORE_OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/hdc_mac.sv
// Shared multiply-accumulate unit: one 16x16 product per cycle into a wide
// accumulator, emitting the sign of each finished dot product. Uses hdc_pkg.
`default_nettype none

module hdc_mac
  import hdc_pkg::*;
#(
  parameter int ACC_W = 38
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire mac_ctl_t                  ctl,
  input  wire logic signed [VALUE_W-1:0] a,
  input  wire logic signed [VALUE_W-1:0] b,
  output logic                           sign_we,
  output logic                           sign_bit,
  output logic                           busy
);

  mac_ctl_t                    ctl1;
  logic signed [2*VALUE_W-1:0] prod;
  logic signed [ACC_W-1:0]     acc;
  logic signed [ACC_W-1:0]     acc_next;

  always_comb begin
    if (ctl1.first) begin
      acc_next = ACC_W'(prod);
    end else begin
      acc_next = acc + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      sign_we <= 1'b0;
    end else begin
      ctl1    <= ctl;
      sign_we <= ctl1.vld & ctl1.lastf;
    end
    prod <= a * b;
    if (ctl1.vld) begin
      acc      <= acc_next;
      sign_bit <= ~acc_next[ACC_W-1];
    end
  end

  assign busy = ctl1.vld | sign_we;

endmodule

`default_nettype wire

### verif/hdc_encode_classify_tb.sv
// Self-checking testbench for hdc_encode_classify: weight loads, a directed table, random samples.
// A local classifier model predicts each result the table does not type, and the checker compares it with the output.
// Depends on hdc_pkg and the hdc_encode_classify RTL.
`default_nettype none

module hdc_encode_classify_tb;
  import hdc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CLASS_SPACE = DIM_C * CLASSES_C;
  localparam int NUM_SAMPLES = 40;

  typedef struct packed {
    logic [CLASS_OUT_W-1:0]        cls;
    logic signed [SCORE_OUT_W-1:0] score;
  } verdict_t;

  typedef struct packed {
    logic [OP_W-1:0]               op;
    logic [ADDR_W-1:0]             addr;
    logic signed [VALUE_W-1:0]     value;
    logic                          last;
    logic                          typed;
    logic [CLASS_OUT_W-1:0]        cls;
    logic signed [SCORE_OUT_W-1:0] score;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] op = '0;
  logic [ADDR_W-1:0] addr = '0;
  logic signed [VALUE_W-1:0] value = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CLASS_OUT_W-1:0] predicted_class;
  logic signed [SCORE_OUT_W-1:0] best_score;

  logic quiet_run = 1'b0;
  int mismatches = 0;
  verdict_t expected_verdicts[$];
  verdict_t want;

  // classifier model state
  logic signed [VALUE_W-1:0] base_mem [ADDR_SPACE];
  logic signed [VALUE_W-1:0] class_mem [CLASS_SPACE];
  logic signed [VALUE_W-1:0] features [FEATURES_C];
  int feature_cnt = 0;

  // Class weights are all zero when this table runs, so the typed rows follow
  // from the few weights the table itself writes.
  plan_row_t plan [19] = '{
    '{OP_SAMPLE, 15'd0,     16'sd0,      1'b1, 1'b1, 4'd0,  26'sd0},
    '{OP_BASE,   15'd0,     16'sd32767,  1'b1, 1'b0, 4'd0,  26'sd0},
    '{OP_CLASS,  15'd5,     16'sd32767,  1'b0, 1'b0, 4'd0,  26'sd0},
    '{OP_SAMPLE, 15'd32767, 16'sd32767,  1'b1, 1'b1, 4'd5,  26'sd32767},
    '{OP_CLASS,  15'd15,    -16'sd32768, 1'b1, 1'b0, 4'd0,  26'sd0},
    '{OP_SAMPLE, 15'd0,     -16'sd32768, 1'b1, 1'b1, 4'd15, 26'sd32768},
    '{OP_UNUSED, 15'd15,    16'sd32767,  1'b1, 1'b0, 4'd0,  26'sd0},
    '{OP_CLASS,  15'd8207,  16'sd32767,  1'b0, 1'b0, 4'd0,  26'sd0},
    '{OP_SAMPLE, 15'd32767, -16'sd32768, 1'b1, 1'b1, 4'd15, 26'sd32768},
    '{OP_CLASS,  15'd32767, 16'sd12345,  1'b0, 1'b0, 4'd0,  26'sd0},
    '{OP_CLASS,  15'd8191,  -16'sd32768, 1'b0, 1'b0, 4'd0,  26'sd0},
    '{OP_CLASS,  15'd0,     16'sd32767,  1'b0, 1'b0, 4'd0,  26'sd0},
    '{OP_SAMPLE, 15'd0,     16'sd32767,  1'b0, 1'b0, 4'd0,  26'sd0},
    '{OP_SAMPLE, 15'd32767, -16'sd32768, 1'b0, 1'b0, 4'd0,  26'sd0},
    '{OP_SAMPLE, 15'd0,     16'sd1,      1'b1, 1'b0, 4'd0,  26'sd0},
    '{OP_BASE,   15'd32767, -16'sd32768, 1'b0, 1'b0, 4'd0,  26'sd0},
    '{OP_BASE,   15'd511,   16'sd32767,  1'b0, 1'b0, 4'd0,  26'sd0},
    '{OP_SAMPLE, 15'd0,     -16'sd1,     1'b1, 1'b0, 4'd0,  26'sd0},
    '{OP_SAMPLE, 15'd0,     16'sd32767,  1'b1, 1'b0, 4'd0,  26'sd0}
  };

  hdc_encode_classify u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .op              (op),
    .addr            (addr),
    .value           (value),
    .last            (last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .predicted_class (predicted_class),
    .best_score      (best_score)
  );

  always #5 clk = ~clk;

  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 7) == 0)
      return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    return VALUE_W'($urandom());
  endfunction

  // Encode the buffered features into signs, then score every class.
  function automatic verdict_t score_sample();
    longint acc;
    longint scores [CLASSES_C];
    longint top;
    int win;
    verdict_t v;
    for (int k = 0; k < CLASSES_C; k++)
      scores[k] = 0;
    for (int d = 0; d < DIM_C; d++) begin
      acc = 0;
      for (int f = 0; f < feature_cnt; f++)
        acc += longint'(features[f]) * longint'(base_mem[f * DIM_C + d]);
      for (int k = 0; k < CLASSES_C; k++) begin
        if (acc >= 0)
          scores[k] += longint'(class_mem[d * CLASSES_C + k]);
        else
          scores[k] -= longint'(class_mem[d * CLASSES_C + k]);
      end
    end
    top = scores[0];
    win = 0;
    for (int k = 1; k < CLASSES_C; k++) begin
      if (scores[k] > top) begin
        top = scores[k];
        win = k;
      end
    end
    if (top > longint'(SCORE_MAX_C))
      top = longint'(SCORE_MAX_C);
    if (top < longint'(SCORE_MIN_C))
      top = longint'(SCORE_MIN_C);
    v.cls = win[CLASS_OUT_W-1:0];
    v.score = top[SCORE_OUT_W-1:0];
    return v;
  endfunction

  function automatic bit classify_item(input logic [OP_W-1:0] o, input logic [ADDR_W-1:0] a,
                                       input logic signed [VALUE_W-1:0] v, input logic l,
                                       output verdict_t res);
    res = '0;
    case (o)
      OP_BASE: base_mem[a] = v;
      OP_CLASS: begin
        if (a < CLASS_SPACE)
          class_mem[a] = v;
      end
      OP_SAMPLE: begin
        // drop features past the buffer depth; last still closes the sample
        if (feature_cnt < FEATURES_C) begin
          features[feature_cnt] = v;
          feature_cnt++;
        end
        if (l) begin
          res = score_sample();
          feature_cnt = 0;
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] o, input logic [ADDR_W-1:0] a,
                           input logic signed [VALUE_W-1:0] v, input logic l,
                           input logic typed, input verdict_t typed_v);
    verdict_t got;
    while (!quiet_run && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    addr <= a;
    value <= v;
    last <= l;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    if (classify_item(o, a, v, l, got))
      expected_verdicts.push_back(typed ? typed_v : got);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: class %0d score %0d", predicted_class, best_score);
      end else begin
        want = expected_verdicts.pop_front();
        if (predicted_class !== want.cls || best_score !== want.score) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result: expected class %0d score %0d, got class %0d score %0d",
                     want.cls, $signed(want.score), predicted_class, best_score);
        end
      end
    end
    out_stall <= !rst && !quiet_run && ($urandom_range(0, 99) < 28);
  end

  initial begin
    int r;
    int n_load;
    int n_feat;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // fill every weight before any sample reads one; class weights start at zero
    for (int a = 0; a < ADDR_SPACE; a++)
      send_item(OP_BASE, a[ADDR_W-1:0], pick_value(), 1'($urandom_range(0, 1)), 1'b0, '0);
    for (int a = 0; a < CLASS_SPACE; a++)
      send_item(OP_CLASS, a[ADDR_W-1:0], 16'sd0, 1'($urandom_range(0, 1)), 1'b0, '0);

    foreach (plan[i])
      send_item(plan[i].op, plan[i].addr, plan[i].value, plan[i].last, plan[i].typed,
                '{plan[i].cls, plan[i].score});

    for (int a = 0; a < CLASS_SPACE; a++)
      send_item(OP_CLASS, a[ADDR_W-1:0], pick_value(), 1'($urandom_range(0, 1)), 1'b0, '0);

    for (int s = 0; s < NUM_SAMPLES; s++) begin
      quiet_run <= (s >= 14 && s < 24);
      n_load = $urandom_range(0, 28);
      repeat (n_load) begin
        r = $urandom_range(0, 99);
        if (r < 45)
          send_item(OP_BASE, ADDR_W'($urandom()), pick_value(), 1'($urandom_range(0, 1)),
                    1'b0, '0);
        else if (r < 90)
          send_item(OP_CLASS, ADDR_W'($urandom_range(0, CLASS_SPACE - 1)), pick_value(),
                    1'($urandom_range(0, 1)), 1'b0, '0);
        else if (r < 95)
          send_item(OP_CLASS, ADDR_W'($urandom_range(CLASS_SPACE, ADDR_SPACE - 1)),
                    pick_value(), 1'($urandom_range(0, 1)), 1'b0, '0);
        else
          send_item(OP_UNUSED, ADDR_W'($urandom()), pick_value(), 1'($urandom_range(0, 1)),
                    1'b0, '0);
      end
      // mostly short samples; a few fill or overflow the feature buffer
      if (s == 6)
        n_feat = FEATURES_C;
      else if (s % 13 == 6)
        n_feat = $urandom_range(FEATURES_C - 2, FEATURES_C + 6);
      else
        n_feat = $urandom_range(1, 6);
      for (int f = 0; f < n_feat; f++)
        send_item(OP_SAMPLE, ADDR_W'($urandom()), pick_value(), f == n_feat - 1, 1'b0, '0);
    end

    in_valid <= 1'b0;
    quiet_run <= 1'b0;
    while (expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_verdicts.size() == 0)
      $display("hdc_encode_classify: match");
    else
      $display("hdc_encode_classify: mismatch");
    $finish;
  end

  initial begin
    #200000000;
    $display("hdc_encode_classify: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
